[hdl/base64_stream_encoder_defines.svh]
// Assertion macros for the Base64 stream encoder.
// Used by the top level; no other dependency.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define B64E_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define B64E_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define B64E_ASSERT_NEVER(label, clk, rst, cond, msg)
`define B64E_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/b64e_pkg.sv]
// Shared types, constants and the sextet alphabet for the Base64 stream encoder.
// No dependencies.
package b64e_pkg;

  localparam logic [7:0] GROUPS_PER_LINE_RESET = 8'd19;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // Register indexes (word address bit 2 and up)
  localparam logic REG_GROUPS_PER_LINE = 1'b0;

  localparam logic [7:0] CHAR_PAD = 8'd61;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;

  // Character slot codes walked by the back end
  localparam logic [2:0] SLOT_LAST_DATA = 3'd3;
  localparam logic [2:0] SLOT_CR        = 3'd4;
  localparam logic [2:0] SLOT_LF        = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  // One four-character group, with or without a trailing CR LF
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Map a 6-bit value to its character of the standard alphabet
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < 6'd26) begin
      c = w + 8'd65;
    end else if (v < 6'd52) begin
      c = w + 8'd71;
    end else if (v < 6'd62) begin
      c = w - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

[hdl/b64e_front.sv]
// Front end: accepts bytes, collects groups of three and builds character jobs.
// Depends on b64e_pkg.
module b64e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_item_t  in_data,
  input  logic [7:0]          groups_per_line,
  input  b64e_pkg::q_status_t q_stat,
  output logic                push,
  output b64e_pkg::job_t      push_job
);

  logic [15:0] pending_bytes;
  logic [15:0] pending_bytes_next;
  logic [1:0]  group_phase;
  logic [1:0]  group_phase_next;
  logic [7:0]  groups_in_line;
  logic [7:0]  groups_in_line_next;

  logic        accept;
  logic [1:0]  phase_eff;
  logic [7:0]  b;
  logic [7:0]  b1;
  logic [7:0]  b2;
  logic [8:0]  cnt;
  logic        brk;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  assign b  = in_data.data_byte;
  assign b1 = pending_bytes[15:8];
  assign b2 = pending_bytes[7:0];
  assign phase_eff = (group_phase == 2'd3) ? 2'd0 : group_phase;
  assign cnt = {1'b0, groups_in_line} + 9'd1;
  assign brk = cnt >= {1'b0, groups_per_line};

  // Classify the byte and build the next state and the job
  always_comb begin
    pending_bytes_next  = pending_bytes;
    group_phase_next    = group_phase;
    groups_in_line_next = groups_in_line;
    push                = 1'b0;
    push_job            = '0;
    if (accept) begin
      case (phase_eff)
        2'd0: begin
          if (!in_data.last_byte) begin
            pending_bytes_next = {b, 8'd0};
            group_phase_next   = 2'd1;
          end else begin
            push              = 1'b1;
            push_job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
            push_job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'd0});
            push_job.chars[2] = b64e_pkg::CHAR_PAD;
            push_job.chars[3] = b64e_pkg::CHAR_PAD;
            pending_bytes_next  = '0;
            group_phase_next    = 2'd0;
            groups_in_line_next = '0;
          end
        end
        2'd1: begin
          if (!in_data.last_byte) begin
            pending_bytes_next = {b1, b};
            group_phase_next   = 2'd2;
          end else begin
            push              = 1'b1;
            push_job.chars[0] = b64e_pkg::sextet_char(b1[7:2]);
            push_job.chars[1] = b64e_pkg::sextet_char({b1[1:0], b[7:4]});
            push_job.chars[2] = b64e_pkg::sextet_char({b[3:0], 2'd0});
            push_job.chars[3] = b64e_pkg::CHAR_PAD;
            pending_bytes_next  = '0;
            group_phase_next    = 2'd0;
            groups_in_line_next = '0;
          end
        end
        default: begin
          push              = 1'b1;
          push_job.chars[0] = b64e_pkg::sextet_char(b1[7:2]);
          push_job.chars[1] = b64e_pkg::sextet_char({b1[1:0], b2[7:4]});
          push_job.chars[2] = b64e_pkg::sextet_char({b2[3:0], b[7:6]});
          push_job.chars[3] = b64e_pkg::sextet_char(b[5:0]);
          push_job.crlf     = brk;
          pending_bytes_next = '0;
          group_phase_next   = 2'd0;
          if (in_data.last_byte || brk) begin
            groups_in_line_next = '0;
          end else begin
            groups_in_line_next = cnt[7:0];
          end
        end
      endcase
    end
  end

  // Hold the group state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes  <= '0;
      group_phase    <= '0;
      groups_in_line <= '0;
    end else begin
      pending_bytes  <= pending_bytes_next;
      group_phase    <= group_phase_next;
      groups_in_line <= groups_in_line_next;
    end
  end

endmodule

[hdl/b64e_queue.sv]
// Short job queue between the front and back ends.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64e_pkg::job_t      push_job,
  input  logic                pop,
  output b64e_pkg::job_t      head,
  output b64e_pkg::q_status_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64e_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = count == CNT_FULL;
  assign stat.empty = count == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  // Store a pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hdl/b64e_back.sv]
// Back end: walks each queued job one character a cycle into the output register, unless stalled.
// Depends on b64e_pkg.
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  b64e_pkg::job_t      head,
  input  b64e_pkg::q_status_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_data
);

  logic [2:0]          slot;
  logic [2:0]          slot_next;
  logic                load;
  b64e_pkg::out_item_t item;

  assign load = !q_stat.empty && (!out_valid || out_ready);

  // Select the character for the current slot
  always_comb begin
    item.last_char = 1'b0;
    case (slot)
      b64e_pkg::SLOT_CR: begin
        item.out_char = b64e_pkg::CHAR_CR;
      end
      b64e_pkg::SLOT_LF: begin
        item.out_char  = b64e_pkg::CHAR_LF;
        item.last_char = 1'b1;
      end
      default: begin
        item.out_char = head.chars[slot[1:0]];
        if (slot == b64e_pkg::SLOT_LAST_DATA && !head.crlf) begin
          item.last_char = 1'b1;
        end
      end
    endcase
  end

  assign pop       = load && item.last_char;
  assign slot_next = pop ? '0 : slot + 3'd1;

  // Advance the slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        slot <= slot_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= item;
    end
  end

endmodule

[hdl/base64_stream_encoder.sv]
// Base64 stream encoder top level: register port, front end, job queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back and the defines header.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one byte per word, with
//   last_byte marking the end of a message. Output channel (out_valid/
//   out_ready/out_data) gives one character per word; last_char marks the
//   final character caused by one input word.
//   Every third byte, or a byte marked last, yields four characters, plus
//   CR LF after groups_per_line groups. Characters leave at one per cycle
//   while the receiver keeps up, from a single output register, so a group
//   is four or six characters. The first character of a group goes through
//   the job queue and the output register after its last byte is accepted.
//   Bytes are taken back to back while the job queue has room; it holds
//   QUEUE_DEPTH groups. A stalled receiver holds the output word and fills
//   the queue, after which in_ready drops.
//   Reset clears the group state and the queue and sets groups_per_line
//   to 19. groups_per_line sits at byte address 0 of the APB port.
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  b64e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output b64e_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]          groups_per_line;
  logic                cfg_wr;
  logic                push;
  logic                pop;
  b64e_pkg::job_t      push_job;
  b64e_pkg::job_t      head;
  b64e_pkg::q_status_t q_stat;
  logic                out_is_cr;
  logic                out_is_lf;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write the line length register
  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= b64e_pkg::GROUPS_PER_LINE_RESET;
    end else if (cfg_wr && paddr[2] == b64e_pkg::REG_GROUPS_PER_LINE) begin
      groups_per_line <= pwdata[7:0];
    end
  end

  // Read back the register
  always_comb begin
    prdata = '0;
    if (paddr[2] == b64e_pkg::REG_GROUPS_PER_LINE) begin
      prdata = {24'd0, groups_per_line};
    end
  end

  b64e_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .groups_per_line (groups_per_line),
    .q_stat          (q_stat),
    .push            (push),
    .push_job        (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Flag line break characters on the output
  assign out_is_cr = out_valid && out_data.out_char == b64e_pkg::CHAR_CR;
  assign out_is_lf = out_valid && out_data.out_char == b64e_pkg::CHAR_LF;

  // Checks
  `B64E_ASSERT_NEVER(a_no_push_when_full, clk, rst, push && q_stat.full, "push into full queue")
  `B64E_ASSERT_IMPLIES(a_ready_tracks_queue, clk, rst, !in_ready, q_stat.full, "needless stall")
  `B64E_ASSERT_IMPLIES(a_cr_not_last, clk, rst, out_is_cr, !out_data.last_char, "CR marked last")
  `B64E_ASSERT_IMPLIES(a_lf_is_last, clk, rst, out_is_lf, out_data.last_char, "LF not marked last")

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for the Base64 stream encoder: feeds message bytes,
// predicts the character stream and compares it word by word. Needs b64e_pkg.
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  b64e_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  b64e_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Bytes waiting for the driver, characters waiting for the monitor
  b64e_pkg::in_item_t  bytes_to_send[$];
  b64e_pkg::out_item_t expected_chars[$];

  // Predictor state
  logic [7:0] held_first = '0;
  logic [7:0] held_second = '0;
  logic [1:0] held_count = '0;
  logic [7:0] line_count = '0;
  logic [7:0] groups_per_line = b64e_pkg::GROUPS_PER_LINE_RESET;

  int bytes_sent = 0;
  int bytes_taken = 0;
  int messages = 0;
  int chars_checked = 0;
  int settings_used = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  logic steady = 1'b0;

  base64_stream_encoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] b64(input logic [5:0] v);
    return B64_ALPHABET[v];
  endfunction

  // Advance the encoder state by one byte and queue the characters it yields
  function automatic void encode_byte(input b64e_pkg::in_item_t word);
    logic [7:0] chars [0:5];
    logic [8:0] groups;
    logic [7:0] b;
    b64e_pkg::out_item_t e;
    int n;
    b = word.data_byte;
    n = 0;
    if (held_count == 2'd0 || held_count == 2'd3) begin
      if (!word.last_byte) begin
        held_first = b;
        held_count = 2'd1;
        return;
      end
      chars[0] = b64(b[7:2]);
      chars[1] = b64({b[1:0], 4'b0000});
      chars[2] = b64e_pkg::CHAR_PAD;
      chars[3] = b64e_pkg::CHAR_PAD;
      n = 4;
    end else if (held_count == 2'd1) begin
      if (!word.last_byte) begin
        held_second = b;
        held_count = 2'd2;
        return;
      end
      chars[0] = b64(held_first[7:2]);
      chars[1] = b64({held_first[1:0], b[7:4]});
      chars[2] = b64({b[3:0], 2'b00});
      chars[3] = b64e_pkg::CHAR_PAD;
      n = 4;
    end else begin
      chars[0] = b64(held_first[7:2]);
      chars[1] = b64({held_first[1:0], held_second[7:4]});
      chars[2] = b64({held_second[3:0], b[7:6]});
      chars[3] = b64(b[5:0]);
      n = 4;
      groups = {1'b0, line_count} + 9'd1;
      // Zero groups per line behaves like one
      if (groups >= {1'b0, groups_per_line}) begin
        chars[4] = b64e_pkg::CHAR_CR;
        chars[5] = b64e_pkg::CHAR_LF;
        n = 6;
        groups = '0;
      end
      line_count = groups[7:0];
    end
    held_first = '0;
    held_second = '0;
    held_count = '0;
    if (word.last_byte) line_count = '0;
    for (int i = 0; i < n; i++) begin
      e.out_char = chars[i];
      e.last_char = (i == n - 1);
      expected_chars.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Driver: hold the word until taken, then load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_byte(in_data);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() > 0 && (steady || $urandom_range(99) >= 10)) begin
          in_data <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each character against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        report_mismatch("character with nothing expected", 32'd0, 32'(out_data));
      end else begin
        if (out_data.out_char !== expected_chars[0].out_char)
          report_mismatch("out_char", 32'(expected_chars[0].out_char),
                          32'(out_data.out_char));
        if (out_data.last_char !== expected_chars[0].last_char)
          report_mismatch("last_char", 32'(expected_chars[0].last_char),
                          32'(out_data.last_char));
        void'(expected_chars.pop_front());
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 10);
  end

  // Watchdog: end the run when outstanding work stops moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (bytes_taken == bytes_sent && expected_chars.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    b64e_pkg::in_item_t w;
    w.data_byte = b;
    w.last_byte = last;
    bytes_to_send.push_back(w);
    bytes_sent++;
    if (last) messages++;
  endtask

  // Hold the sender until every predicted character has come out
  task automatic wait_drained;
    while (bytes_taken != bytes_sent || expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [7:0] value,
                            output logic [7:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {b64e_pkg::REG_GROUPS_PER_LINE, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write the line length once the encoder has settled, then read it back
  task automatic set_groups_per_line(input logic [7:0] value);
    logic [7:0] rdata;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_access(1'b1, value, rdata);
    groups_per_line = value;
    settings_used++;
    @(posedge clk);
    apb_access(1'b0, 8'd0, rdata);
    if (rdata !== value)
      report_mismatch("groups_per_line readback", 32'(value), 32'(rdata));
  endtask

  task automatic random_phase(input logic [7:0] setting, input int count,
                              input int last_pct);
    set_groups_per_line(setting);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) wait_drained();
      send_byte(8'($urandom_range(255)), $urandom_range(99) < last_pct);
    end
  endtask

  initial begin
    logic [7:0] rdata;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, 8'd0, rdata);
    if (rdata !== b64e_pkg::GROUPS_PER_LINE_RESET)
      report_mismatch("groups_per_line after reset",
                      32'(b64e_pkg::GROUPS_PER_LINE_RESET), 32'(rdata));

    // One-byte and two-byte tails with extreme values
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // Full groups that end the message
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);

    // Zero groups per line: break after every group, even the last one
    set_groups_per_line(8'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);

    // Lower the line length in the middle of a line and of a message
    set_groups_per_line(b64e_pkg::GROUPS_PER_LINE_RESET);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b0);
    set_groups_per_line(8'd1);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h11, 1'b1);

    // Random messages under a spread of line lengths; phases may end mid-message
    random_phase(8'd255, 50, 5);
    random_phase(8'd1, 50, 30);
    random_phase(8'd2, 50, 10);
    steady = 1'b1;
    random_phase(b64e_pkg::GROUPS_PER_LINE_RESET, 50, 2);
    wait_drained();
    steady = 1'b0;
    random_phase(8'd0, 50, 20);
    random_phase(8'($urandom_range(4, 254)), 50, 3);
    random_phase(8'd3, 50, 15);
    random_phase(8'd128, 50, 8);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Encoded %0d bytes in %0d finished messages, %0d characters checked.",
             bytes_sent, messages, chars_checked);
    $display("Line length was changed %0d times, from 0 up to 255 groups.",
             settings_used);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/b64e_pkg.sv
hdl/b64e_front.sv
hdl/b64e_queue.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
test/testbench.sv
